>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Widths, microcode types and the control ROM of the minimum-squares block.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int MAX_VALUE  = 1023;
    localparam int BASE_LIMIT = 4;
    localparam int TARGET_W   = 10;
    localparam int COUNT_W    = 3;
    localparam int ADDR_W     = $clog2(MAX_VALUE + 1);
    localparam int SQUARE_W   = ADDR_W + 1;
    localparam int ROOT_W     = (ADDR_W + 1) / 2 + 1;
    localparam int DEPTH      = MAX_VALUE + 1;
    localparam int UPC_W      = 3;

    typedef logic [UPC_W-1:0] upc_t;

    // Program step addresses
    localparam upc_t STEP_IDLE     = 3'd0;
    localparam upc_t STEP_BASE     = 3'd1;
    localparam upc_t STEP_BRANCH   = 3'd2;
    localparam upc_t STEP_ROW_INIT = 3'd3;
    localparam upc_t STEP_LOOP     = 3'd4;
    localparam upc_t STEP_ROW_WR   = 3'd5;
    localparam upc_t STEP_SMALL    = 3'd6;
    localparam upc_t STEP_DONE     = 3'd7;

    // Datapath action of one step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_BASE_WR,
        ACT_ROW_INIT,
        ACT_INNER,
        ACT_ROW_WR,
        ACT_SMALL,
        ACT_EMIT
    } act_t;

    // Jump condition of one step
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_XFER,
        COND_BASE_LAST,
        COND_SMALL,
        COND_LOOP_DONE,
        COND_ROW_LAST,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  jump_true;
        upc_t  jump_false;
    } ctl_word_t;

    // Control store
    function automatic ctl_word_t msq_rom(input upc_t upc);
        ctl_word_t w;
        unique case (upc)
            STEP_IDLE:     w = '{ACT_LOAD,     COND_IN_XFER,   STEP_BASE,     STEP_IDLE};
            STEP_BASE:     w = '{ACT_BASE_WR,  COND_BASE_LAST, STEP_BRANCH,   STEP_BASE};
            STEP_BRANCH:   w = '{ACT_NONE,     COND_SMALL,     STEP_SMALL,    STEP_ROW_INIT};
            STEP_ROW_INIT: w = '{ACT_ROW_INIT, COND_ALWAYS,    STEP_LOOP,     STEP_LOOP};
            STEP_LOOP:     w = '{ACT_INNER,    COND_LOOP_DONE, STEP_ROW_WR,   STEP_LOOP};
            STEP_ROW_WR:   w = '{ACT_ROW_WR,   COND_ROW_LAST,  STEP_DONE,     STEP_ROW_INIT};
            STEP_SMALL:    w = '{ACT_SMALL,    COND_ALWAYS,    STEP_DONE,     STEP_DONE};
            STEP_DONE:     w = '{ACT_EMIT,     COND_OUT_FREE,  STEP_IDLE,     STEP_DONE};
            default:       w = '{ACT_NONE,     COND_ALWAYS,    STEP_IDLE,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> src/msq_in_if.sv
// ----------------------------------------------------------------------------
// msq_in_if
// Valid/ready channel carrying one target value per transfer.
// ----------------------------------------------------------------------------
interface msq_in_if
    import msq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target_value;

    modport source (output valid, output target_value, input ready);
    modport sink   (input valid, input target_value, output ready);
endinterface

>>> src/msq_out_if.sv
// ----------------------------------------------------------------------------
// msq_out_if
// Valid/ready channel carrying one square count per transfer.
// ----------------------------------------------------------------------------
interface msq_out_if
    import msq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] square_count;

    modport source (output valid, output square_count, input ready);
    modport sink   (input valid, input square_count, output ready);
endinterface

>>> src/min_squares_sum_count_top.sv
// ----------------------------------------------------------------------------
// min_squares_sum_count_top
// Least number of perfect squares summing to a target, by a bottom-up table
// fill driven from a small microcoded control store.
// ----------------------------------------------------------------------------
// Usage:
//   target_ch (sink) takes one target_value per transfer; result_ch (source)
//   returns one square_count per target, in order.
//   target_ch.ready is high only while the sequencer sits in its idle step;
//   a new target may be taken while the previous result still waits.
// Table fill:
//   targets 0..3 take the small path and skip the row fill; a larger target T
//   fills one row per value from 4 to T. The run time is set by the inner loop,
//   which reads one table entry per cycle through the single read port of
//   the count table.
//   The block takes no new target until the previous one has been handed
//   to the output register.
// Reset: asynchronous, active low; returns to the idle step with no result
//   pending. The count table is not cleared: each target refills it.
// Stall: a result holds on result_ch until taken; the sequencer waits in its
//   final step if the previous result has not left the output register.
// ----------------------------------------------------------------------------
module min_squares_sum_count_top
    import msq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    msq_in_if.sink    target_ch,
    msq_out_if.source result_ch
);

    // Sequencer state
    upc_t                upc_reg, upc_next;
    ctl_word_t           ctl;
    logic                cond_hit;

    // Datapath registers
    logic [ADDR_W-1:0]   target_reg;
    logic [ADDR_W-1:0]   outer_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQUARE_W-1:0] square_reg;
    logic [COUNT_W-1:0]  min_reg;
    logic                pend_reg;
    logic [COUNT_W-1:0]  rd_data_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_data_reg;

    // Count table
    logic [COUNT_W-1:0]  count_mem [DEPTH];

    logic                in_xfer;
    logic                out_free;
    logic                sq_gt;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   target_clamped;
    logic [COUNT_W-1:0]  cand;
    logic                mem_we;
    logic [COUNT_W-1:0]  mem_wdata;

    assign ctl      = msq_rom(upc_reg);
    assign in_xfer  = target_ch.valid && target_ch.ready;
    assign out_free = !out_valid_reg || result_ch.ready;
    assign sq_gt    = square_reg > {1'b0, outer_reg};
    assign rd_addr  = outer_reg - square_reg[ADDR_W-1:0];
    assign cand     = rd_data_reg + COUNT_W'(1);

    assign target_clamped = (target_ch.target_value > TARGET_W'(MAX_VALUE))
                          ? ADDR_W'(MAX_VALUE) : ADDR_W'(target_ch.target_value);

    assign target_ch.ready        = (ctl.act == ACT_LOAD);
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.square_count = out_data_reg;

    // Jump condition select
    always_comb
    begin
        unique case (ctl.cond)
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_IN_XFER:   cond_hit = in_xfer;
            COND_BASE_LAST: cond_hit = (outer_reg == ADDR_W'(BASE_LIMIT - 1));
            COND_SMALL:     cond_hit = (target_reg < ADDR_W'(BASE_LIMIT));
            COND_LOOP_DONE: cond_hit = sq_gt && !pend_reg;
            COND_ROW_LAST:  cond_hit = (outer_reg == target_reg);
            COND_OUT_FREE:  cond_hit = out_free;
            default:        cond_hit = 1'b1;
        endcase
        upc_next = cond_hit ? ctl.jump_true : ctl.jump_false;
    end

    // Table write port: base entries hold their index, rows hold the minimum
    assign mem_we    = (ctl.act == ACT_BASE_WR) || (ctl.act == ACT_ROW_WR);
    assign mem_wdata = (ctl.act == ACT_BASE_WR) ? outer_reg[COUNT_W-1:0] : min_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[outer_reg] <= mem_wdata;
        end
        rd_data_reg <= count_mem[rd_addr];
    end

    // Sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= STEP_IDLE;
            target_reg    <= '0;
            outer_reg     <= '0;
            root_reg      <= '0;
            square_reg    <= '0;
            min_reg       <= '1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            upc_reg <= upc_next;

            // Output register: load on emit, else drop once taken
            if ((ctl.act == ACT_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= min_reg;
            end
            else if (out_valid_reg && result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (ctl.act)
                ACT_LOAD:
                begin
                    if (in_xfer)
                    begin
                        target_reg <= target_clamped;
                        outer_reg  <= '0;
                    end
                end
                ACT_BASE_WR:
                begin
                    outer_reg <= outer_reg + ADDR_W'(1);
                end
                ACT_ROW_INIT:
                begin
                    min_reg    <= '1;
                    root_reg   <= ROOT_W'(1);
                    square_reg <= SQUARE_W'(1);
                    pend_reg   <= 1'b0;
                end
                ACT_INNER:
                begin
                    // fold the entry read last cycle
                    if (pend_reg && (cand < min_reg))
                    begin
                        min_reg <= cand;
                    end
                    // issue the next read; (r+1)^2 = r^2 + 2r + 1
                    if (!sq_gt)
                    begin
                        root_reg   <= root_reg + ROOT_W'(1);
                        square_reg <= square_reg + (SQUARE_W'(root_reg) << 1)
                                    + SQUARE_W'(1);
                        pend_reg   <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                ACT_ROW_WR:
                begin
                    outer_reg <= outer_reg + ADDR_W'(1);
                end
                ACT_SMALL:
                begin
                    min_reg <= target_reg[COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> src/msq_checker.sv
// ----------------------------------------------------------------------------
// msq_checker
// Port-level checks of the minimum-squares block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msq_checker
    import msq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COUNT_W-1:0] square_count
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] open_reg;
    logic [1:0] open_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Targets taken but not yet answered
    always_comb
    begin
        open_next = open_reg;
        if (in_xfer && !out_xfer)
        begin
            open_next = open_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready)
    `ASSERT_IMPL(a_count_range, out_valid, square_count <= COUNT_W'(4))
    `ASSERT_IMPL(a_no_extra_result, out_valid, open_reg != 2'd0)
    `ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(square_count))

endmodule

bind min_squares_sum_count_top msq_checker u_msq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (target_ch.valid),
    .in_ready     (target_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .square_count (result_ch.square_count)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum-squares block. Targets go in over a
// valid/ready channel in random bursts, and the square counts come back on a
// second channel under a changing stall pattern. A behavioral table fill
// predicts each count not typed in the directed table, and results are
// checked in order. A directed table covers the small targets, the field
// extremes and known counts. A random part follows, mostly small targets with a few spread over 256 to 1023.
// ----------------------------------------------------------------------------
module tb_top;
    import msq_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_TARGETS = 100;
    localparam int DRAIN_CYCLES   = 40;
    // Worst case: every target at 1023, plus stalls and gaps, x3
    localparam int CYCLE_LIMIT    = 10_000_000;
    localparam int NUM_DIRECTED   = 19;

    // How a directed row is checked
    localparam bit CHECK_TYPED     = 1'b1;
    localparam bit CHECK_PREDICTED = 1'b0;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        bit                  typed;
        logic [COUNT_W-1:0]  count;
    } target_row_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [COUNT_W-1:0]  count;
    } pending_count_t;

    logic clk;
    logic rst_n;

    msq_in_if  target_ch ();
    msq_out_if result_ch ();

    min_squares_sum_count_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .target_ch (target_ch),
        .result_ch (result_ch)
    );

    pending_count_t     pending_counts[$];
    logic [COUNT_W-1:0] tally_table [0:DEPTH-1];
    target_row_t        directed_rows [NUM_DIRECTED];
    int                 mismatch_count;
    int                 cycle_count;
    int                 burst_left;

    // Clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Bottom-up fill of the minimum-squares table, refilled for every target
    function automatic logic [COUNT_W-1:0] predict_square_count(
        input logic [TARGET_W-1:0] value
    );
        int unsigned        goal;
        int unsigned        row;
        int unsigned        root;
        int unsigned        square;
        logic [COUNT_W-1:0] least;
        logic [COUNT_W-1:0] cand;

        goal = 32'(value);
        if (goal > MAX_VALUE)
            goal = MAX_VALUE;
        for (int k = 0; k < BASE_LIMIT; k++)
            tally_table[k] = COUNT_W'(k);
        if (goal < BASE_LIMIT)
            return COUNT_W'(goal);
        for (row = BASE_LIMIT; row <= goal; row++)
        begin
            least  = '1;
            root   = 1;
            square = 1;
            while (square <= row)
            begin
                cand = tally_table[row - square] + 1'b1;
                if (cand < least)
                    least = cand;
                root++;
                square = root * root;
            end
            tally_table[row] = least;
        end
        return tally_table[goal];
    endfunction

    // Offer one target; entered and left at a falling edge
    task automatic send_target(
        input logic [TARGET_W-1:0] value,
        input bit                  typed,
        input logic [COUNT_W-1:0]  typed_count
    );
        int             gap;
        pending_count_t entry;

        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
            if (gap != 0)
            begin
                target_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        target_ch.valid        <= 1'b1;
        target_ch.target_value <= value;
        @(posedge clk);
        while (!target_ch.ready)
            @(posedge clk);
        // transfer taken at this edge
        entry.target = value;
        entry.count  = typed ? typed_count : predict_square_count(value);
        pending_counts.push_back(entry);
        burst_left--;
        @(negedge clk);
    endtask

    // Hold off the sender until every count is back
    task automatic wait_drained();
        target_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_counts.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // Result stall pattern, with no-stall stretches mixed in
    initial
    begin : receiver
        logic [31:0] stall_pattern;
        int          hold;

        result_ch.ready = 1'b0;
        stall_pattern   = '1;
        hold            = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
                hold          = $urandom_range(16, 64);
            end
            result_ch.ready <= stall_pattern[0];
            stall_pattern    = {stall_pattern[0], stall_pattern[31:1]};
            hold--;
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        pending_count_t entry;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: unexpected square_count: expected none, got %0d",
                         $time, result_ch.square_count);
                mismatch_count++;
            end
            else
            begin
                entry = pending_counts.pop_front();
                if (result_ch.square_count !== entry.count)
                begin
                    $display("%0t: square_count for target %0d: expected %0d, got %0d",
                             $time, entry.target, entry.count, result_ch.square_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d counts outstanding",
                     $time, pending_counts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int                  sel;
        logic [TARGET_W-1:0] value;

        mismatch_count         = 0;
        cycle_count            = 0;
        burst_left             = 0;
        rst_n                  = 1'b0;
        target_ch.valid        = 1'b0;
        target_ch.target_value = '0;

        // small targets, known counts, alternating bit patterns, extremes
        directed_rows = '{
            '{10'd0,    CHECK_TYPED,     3'd0},
            '{10'd1,    CHECK_TYPED,     3'd1},
            '{10'd2,    CHECK_TYPED,     3'd2},
            '{10'd3,    CHECK_TYPED,     3'd3},
            '{10'd4,    CHECK_TYPED,     3'd1},
            '{10'd5,    CHECK_PREDICTED, 3'd0},
            '{10'd6,    CHECK_PREDICTED, 3'd0},
            '{10'd7,    CHECK_TYPED,     3'd4},
            '{10'd8,    CHECK_PREDICTED, 3'd0},
            '{10'd12,   CHECK_PREDICTED, 3'd0},
            '{10'd15,   CHECK_TYPED,     3'd4},
            '{10'd16,   CHECK_TYPED,     3'd1},
            '{10'd28,   CHECK_TYPED,     3'd4},
            '{10'd341,  CHECK_PREDICTED, 3'd0},
            '{10'd682,  CHECK_PREDICTED, 3'd0},
            '{10'd512,  CHECK_PREDICTED, 3'd0},
            '{10'd961,  CHECK_TYPED,     3'd1},
            '{10'd1022, CHECK_PREDICTED, 3'd0},
            '{10'd1023, CHECK_TYPED,     3'd4}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_target(directed_rows[i].target, directed_rows[i].typed,
                        directed_rows[i].count);
        wait_drained();

        // Random targets, weighted toward small values to keep the run short
        for (int n = 0; n < RANDOM_TARGETS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                value = TARGET_W'($urandom_range(0, 63));
            else if (sel < 95)
                value = TARGET_W'($urandom_range(64, 255));
            else
                value = TARGET_W'($urandom_range(256, 1023));
            send_target(value, CHECK_PREDICTED, '0);
            if (n == RANDOM_TARGETS / 2)
                wait_drained();
        end
        target_ch.valid <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
